@@ src/bim_pkg.sv @@
// ---------------------------------------------------------------------------
// bim_pkg
// Shared types and constants for the broadcast index mapper.
// ---------------------------------------------------------------------------
package bim_pkg;

    localparam int EXT_W = 13;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHAPE = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic ovf;
    } pipe_ctl_t;

endpackage

@@ src/broadcast_index_map.sv @@
// ---------------------------------------------------------------------------
// broadcast_index_map
// Maps a row-major index of a broadcast result to the row-major index of
// its source element, with shape and range status.
//
//   channel  ports                                   direction
//   s_       s_valid s_ready s_dst_index             in
//   m_       m_valid m_ready m_src_index m_status    out
//   cfg_     cfg_valid cfg_ready cfg_index cfg_data  in
//
// One item per cycle while the output is not stalled at m_; one stage per
// index bit converts to coordinates, one multiply stage per dimension
// re-encodes, one output register sets status.
// Reset clears valid bits and sets every extent to one.
// A stall at m_ holds the whole pipeline; s_ready drops with it.
// ---------------------------------------------------------------------------
module broadcast_index_map
    import bim_pkg::*;
#(
    parameter int RANK       = 4,
    parameter int INDEX_BITS = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [INDEX_BITS-1:0]           s_dst_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [INDEX_BITS-1:0]           m_src_index,
    output logic [1:0]                      m_status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [$clog2(2*RANK):0]         cfg_index,
    input  logic [EXT_W-1:0]                cfg_data
);

    localparam int ADDR_W = $clog2(2*RANK) + 1;

    logic [RANK-1:0][EXT_W-1:0] src_ext_reg;
    logic [RANK-1:0][EXT_W-1:0] dst_ext_reg;
    logic                       shape_err_reg, shape_err_next;
    logic                       pipe_en;

    pipe_ctl_t                  dctl [0:INDEX_BITS];
    logic [RANK-1:0][EXT_W-1:0] ddig [0:INDEX_BITS];
    logic [INDEX_BITS-1:0]      dbits [0:INDEX_BITS];

    pipe_ctl_t                  ectl [0:RANK];
    logic [RANK-1:0][EXT_W-1:0] edig [0:RANK];
    logic [INDEX_BITS-1:0]      eacc [0:RANK];

    logic                       out_valid_reg;
    logic [INDEX_BITS-1:0]      out_index_reg, out_index_next;
    status_t                    out_status_reg, out_status_next;

    assign cfg_ready = 1'b1;
    assign pipe_en   = !out_valid_reg || m_ready;
    assign s_ready   = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < RANK; d++) begin
                src_ext_reg[d] <= EXT_W'(1);
                dst_ext_reg[d] <= EXT_W'(1);
            end
        end else if (cfg_valid) begin
            for (int d = 0; d < RANK; d++) begin
                if (cfg_index == ADDR_W'(d)) begin
                    src_ext_reg[d] <= cfg_data;
                end
                if (cfg_index == ADDR_W'(d + RANK)) begin
                    dst_ext_reg[d] <= cfg_data;
                end
            end
        end
    end

    always_comb begin
        shape_err_next = 1'b0;
        for (int d = 0; d < RANK; d++) begin
            if (src_ext_reg[d] == '0 || dst_ext_reg[d] == '0) begin
                shape_err_next = 1'b1;
            end
            if (src_ext_reg[d] != EXT_W'(1) && src_ext_reg[d] != dst_ext_reg[d]) begin
                shape_err_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_err_reg <= 1'b0;
        end else begin
            shape_err_reg <= shape_err_next;
        end
    end

    assign dctl[0].valid = s_valid;
    assign dctl[0].ovf   = 1'b0;
    assign ddig[0]       = '0;
    assign dbits[0]      = s_dst_index;

    for (genvar i = 0; i < INDEX_BITS; i++) begin : g_digit
        bim_digit_stage #(
            .RANK       (RANK),
            .INDEX_BITS (INDEX_BITS)
        ) u_digit (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .dst_ext  (dst_ext_reg),
            .ctl_in   (dctl[i]),
            .dig_in   (ddig[i]),
            .bits_in  (dbits[i]),
            .ctl_out  (dctl[i+1]),
            .dig_out  (ddig[i+1]),
            .bits_out (dbits[i+1])
        );
    end

    assign ectl[0] = dctl[INDEX_BITS];
    assign edig[0] = ddig[INDEX_BITS];
    assign eacc[0] = '0;

    for (genvar d = 0; d < RANK; d++) begin : g_encode
        bim_encode_stage #(
            .RANK       (RANK),
            .INDEX_BITS (INDEX_BITS),
            .DIM        (d)
        ) u_encode (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .src_ext (src_ext_reg),
            .ctl_in  (ectl[d]),
            .dig_in  (edig[d]),
            .acc_in  (eacc[d]),
            .ctl_out (ectl[d+1]),
            .dig_out (edig[d+1]),
            .acc_out (eacc[d+1])
        );
    end

    always_comb begin
        if (shape_err_reg) begin
            out_status_next = ST_SHAPE;
            out_index_next  = '0;
        end else if (ectl[RANK].ovf) begin
            out_status_next = ST_RANGE;
            out_index_next  = '0;
        end else begin
            out_status_next = ST_OK;
            out_index_next  = eacc[RANK];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= ectl[RANK].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_src_index = out_index_reg;
    assign m_status    = out_status_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_src_index == '0)
        else $error("error item carries a nonzero index");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(dctl[1].valid))
        else $error("first stage moved during stall");

endmodule

@@ src/bim_digit_stage.sv @@
// ---------------------------------------------------------------------------
// bim_digit_stage
// One index bit per stage: doubles the mixed-radix coordinate word, adds
// the next index bit and propagates carries outward; a carry out of the
// outermost digit flags an index past the element count.
// ---------------------------------------------------------------------------
module bim_digit_stage
    import bim_pkg::*;
#(
    parameter int RANK       = 4,
    parameter int INDEX_BITS = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic [RANK-1:0][EXT_W-1:0]      dst_ext,
    input  pipe_ctl_t                       ctl_in,
    input  logic [RANK-1:0][EXT_W-1:0]      dig_in,
    input  logic [INDEX_BITS-1:0]           bits_in,
    output pipe_ctl_t                       ctl_out,
    output logic [RANK-1:0][EXT_W-1:0]      dig_out,
    output logic [INDEX_BITS-1:0]           bits_out
);

    pipe_ctl_t                  ctl_reg, ctl_next;
    logic [RANK-1:0][EXT_W-1:0] dig_reg, dig_next;
    logic [INDEX_BITS-1:0]      bits_reg, bits_next;

    always_comb begin
        logic         carry;
        logic [EXT_W:0] t;
        carry = bits_in[INDEX_BITS-1];
        dig_next = dig_in;
        for (int d = RANK - 1; d >= 0; d--) begin
            t = {dig_in[d], 1'b0} + {{EXT_W{1'b0}}, carry};
            if (t >= {1'b0, dst_ext[d]}) begin
                dig_next[d] = EXT_W'(t - {1'b0, dst_ext[d]});
                carry = 1'b1;
            end else begin
                dig_next[d] = t[EXT_W-1:0];
                carry = 1'b0;
            end
        end
        ctl_next.valid = ctl_in.valid;
        ctl_next.ovf   = ctl_in.ovf | carry;
        bits_next      = {bits_in[INDEX_BITS-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dig_reg  <= dig_next;
            bits_reg <= bits_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign dig_out  = dig_reg;
    assign bits_out = bits_reg;

endmodule

@@ src/bim_encode_stage.sv @@
// ---------------------------------------------------------------------------
// bim_encode_stage
// One dimension of the row-major source encode: acc * extent + coordinate,
// with broadcast dimensions contributing a zero coordinate.
// ---------------------------------------------------------------------------
module bim_encode_stage
    import bim_pkg::*;
#(
    parameter int RANK       = 4,
    parameter int INDEX_BITS = 48,
    parameter int DIM        = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic [RANK-1:0][EXT_W-1:0]      src_ext,
    input  pipe_ctl_t                       ctl_in,
    input  logic [RANK-1:0][EXT_W-1:0]      dig_in,
    input  logic [INDEX_BITS-1:0]           acc_in,
    output pipe_ctl_t                       ctl_out,
    output logic [RANK-1:0][EXT_W-1:0]      dig_out,
    output logic [INDEX_BITS-1:0]           acc_out
);

    pipe_ctl_t                  ctl_reg;
    logic [RANK-1:0][EXT_W-1:0] dig_reg;
    logic [INDEX_BITS-1:0]      acc_reg, acc_next;
    logic [INDEX_BITS+EXT_W-1:0] prod;
    logic [EXT_W-1:0]           coord;

    always_comb begin
        prod     = {{EXT_W{1'b0}}, acc_in} * {{INDEX_BITS{1'b0}}, src_ext[DIM]};
        coord    = (src_ext[DIM] == EXT_W'(1)) ? '0 : dig_in[DIM];
        acc_next = prod[INDEX_BITS-1:0] + {{(INDEX_BITS-EXT_W){1'b0}}, coord};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dig_reg <= dig_in;
            acc_reg <= acc_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign dig_out = dig_reg;
    assign acc_out = acc_reg;

endmodule

@@ dv/tb_broadcast_index_map.sv @@
// ---------------------------------------------------------------------------
// tb_broadcast_index_map
// Self-checking bench for the broadcast index mapper. A predictor splits each
// result index into coordinates, zeroes broadcast dimensions and re-encodes
// the source index; results are compared field by field against a queue of
// expected source indexes and status codes; the random test idles both sides.
// ---------------------------------------------------------------------------
module tb_broadcast_index_map;
    import bim_pkg::*;

    localparam int RANK       = 4;
    localparam int INDEX_BITS = 48;
    localparam int CFG_W      = $clog2(2*RANK) + 1;
    localparam int LATENCY    = INDEX_BITS + RANK + 1;
    localparam int REG_SRC0   = 0;
    localparam int REG_DST0   = RANK;
    localparam int REG_COUNT  = 2 * RANK;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef struct packed {
        index_t  src_index;
        status_t status;
    } mapping_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    index_t            s_dst_index = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    index_t            m_src_index;
    logic [1:0]        m_status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index = '0;
    logic [EXT_W-1:0]  cfg_data = '0;

    logic [EXT_W-1:0]  src_shape [RANK];
    logic [EXT_W-1:0]  dst_shape [RANK];
    mapping_t          pending_maps [$];
    int                error_count = 0;
    int                results_seen = 0;
    int                items_sent = 0;
    longint            cycle_count = 0;
    bit                rx_idle = 1'b0;
    int                status_hits [3];

    broadcast_index_map #(.RANK(RANK), .INDEX_BITS(INDEX_BITS)) dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit reached");
            $display("tb_broadcast_index_map: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic mapping_t map_index(index_t dst_idx);
        mapping_t res;
        logic [127:0] count;
        logic [127:0] rest;
        logic [127:0] acc;
        logic [63:0] coord [RANK];
        bit huge;
        res.src_index = '0;
        res.status = ST_OK;
        for (int d = 0; d < RANK; d++) begin
            if (src_shape[d] == 0 || dst_shape[d] == 0 ||
                (src_shape[d] != 1 && src_shape[d] != dst_shape[d])) begin
                res.status = ST_SHAPE;
                return res;
            end
        end
        count = 1;
        huge = 1'b0;
        for (int d = 0; d < RANK; d++) begin
            if (count > ((128'd1 << INDEX_BITS) / dst_shape[d])) huge = 1'b1;
            else count = count * dst_shape[d];
        end
        if (!huge && dst_idx >= count) begin
            res.status = ST_RANGE;
            return res;
        end
        rest = dst_idx;
        for (int d = RANK - 1; d >= 0; d--) begin
            coord[d] = rest % dst_shape[d];
            rest = rest / dst_shape[d];
        end
        acc = 0;
        for (int d = 0; d < RANK; d++)
            acc = acc * src_shape[d] + ((src_shape[d] == 1) ? 0 : coord[d]);
        res.src_index = acc[INDEX_BITS-1:0];
        return res;
    endfunction

    task automatic write_reg(int idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_W-1:0];
        cfg_data  <= value[EXT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        if (idx < REG_DST0) src_shape[idx] = value[EXT_W-1:0];
        else if (idx < REG_COUNT) dst_shape[idx - REG_DST0] = value[EXT_W-1:0];
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_shapes(int s0, int s1, int s2, int s3,
                              int d0, int d1, int d2, int d3);
        drain();
        write_reg(REG_SRC0 + 0, s0);
        write_reg(REG_SRC0 + 1, s1);
        write_reg(REG_SRC0 + 2, s2);
        write_reg(REG_SRC0 + 3, s3);
        write_reg(REG_DST0 + 0, d0);
        write_reg(REG_DST0 + 1, d1);
        write_reg(REG_DST0 + 2, d2);
        write_reg(REG_DST0 + 3, d3);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(index_t idx, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_dst_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_maps = {pending_maps, map_index(idx)};
        items_sent++;
    endtask

    function automatic index_t element_count();
        logic [127:0] c;
        c = 1;
        for (int d = 0; d < RANK; d++) c = c * dst_shape[d];
        return (c >= (128'd1 << INDEX_BITS)) ? '1 : c[INDEX_BITS-1:0];
    endfunction

    function automatic index_t rand_index();
        index_t n;
        int r;
        n = element_count();
        r = $urandom_range(0, 9);
        if (r == 0) return index_t'({$urandom, $urandom});
        if (r == 1) return n + index_t'($urandom_range(0, 3));
        if (r == 2) return n - 1;
        if (n <= 1) return 0;
        return index_t'({$urandom, $urandom} % n);
    endfunction

    always @(posedge aclk) begin
        mapping_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_maps.size() == 0) begin
                $error("result with nothing expected: src_index %0h", m_src_index);
                error_count++;
            end else begin
                want = pending_maps.pop_front();
                if (m_status < 3) status_hits[m_status]++;
                if (m_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_status);
                    error_count++;
                end
                if (m_src_index !== want.src_index) begin
                    $error("src_index expected %0h actual %0h",
                           want.src_index, m_src_index);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (rx_idle) begin
                m_ready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic test_reset_shape();
        send_item('0, 0);
        send_item(1, 0);
        send_item('1, 0);
    endtask

    task automatic test_directed();
        set_shapes(1, 3, 1, 5, 2, 3, 4, 5);
        for (int i = 0; i < 6; i++) send_item(i * 23, 0);
        send_item(119, 0);
        send_item(120, 0);
        send_item('1, 0);
        set_shapes(0, 1, 1, 1, 1, 1, 1, 1);
        send_item(0, 0);
        set_shapes(1, 1, 1, 1, 1, 0, 1, 1);
        send_item(0, 0);
        set_shapes(1, 4, 1, 1, 1, 1, 1, 1);
        send_item(0, 0);
        set_shapes(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096);
        send_item('1, 0);
        send_item(48'h123456789abc, 0);
        send_item('0, 0);
        set_shapes(8191, 1, 8191, 1, 8191, 8191, 8191, 8191);
        send_item('1, 0);
        send_item(48'h5555_aaaa_5555, 0);
    endtask

    function automatic int rand_extent();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 8191;
        if (r == 2) return 4096;
        if (r < 6) return 1;
        return $urandom_range(2, 40);
    endfunction

    task automatic test_random(int items);
        int s [RANK];
        int d [RANK];
        int sent;
        sent = 0;
        while (sent < items) begin
            for (int k = 0; k < RANK; k++) begin
                d[k] = rand_extent();
                s[k] = ($urandom_range(0, 1) == 0) ? 1 : d[k];
                if ($urandom_range(0, 14) == 0) s[k] = rand_extent();
            end
            set_shapes(s[0], s[1], s[2], s[3], d[0], d[1], d[2], d[3]);
            for (int i = 0; i < 40 && sent < items; i++) begin
                send_item(rand_index(), 1);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        for (int d = 0; d < RANK; d++) begin
            src_shape[d] = 1;
            dst_shape[d] = 1;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rx_idle = 1'b1;
        test_reset_shape();
        test_directed();
        rx_idle = 1'b0;
        test_random(830);
        drain();
        $display("sent %0d items, checked %0d results over random shapes", items_sent,
                 results_seen);
        $display("status counts: ok %0d, shape %0d, range %0d",
                 status_hits[0], status_hits[1], status_hits[2]);
        if (error_count == 0 && pending_maps.size() == 0)
            $display("tb_broadcast_index_map: done, clean");
        else
            $display("tb_broadcast_index_map: done, errors");
        $finish;
    end

endmodule

@@ broadcast_index_map.f @@
src/bim_pkg.sv
src/bim_digit_stage.sv
src/bim_encode_stage.sv
src/broadcast_index_map.sv
dv/tb_broadcast_index_map.sv
